[rtl/ptt_pkg.sv]
`timescale 1ns / 1ps

package ptt_pkg;

    // Default for the longest read the block scans.
    localparam int MAX_READ_LEN_DEF = 1024;

    // Fixed field widths.
    localparam int BASE_W     = 8;
    localparam int MIN_RUN_W  = 11;
    localparam int KEPT_W     = 11;
    localparam int MISMATCH_W = 3;

    // One mismatch is allowed per 2**MISMATCH_SPAN_LOG2 bases scanned.
    localparam int MISMATCH_SPAN_LOG2 = 3;
    localparam logic [MISMATCH_W-1:0] MISMATCH_CAP = 3'd5;

    // Configuration register reset values.
    localparam logic [BASE_W-1:0]    TARGET_BASE_RST = 8'd71;
    localparam logic [MIN_RUN_W-1:0] MIN_RUN_RST     = 11'd10;

    // Configuration register indexes.
    localparam logic REG_TARGET_BASE = 1'b0;
    localparam logic REG_MIN_RUN     = 1'b1;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef struct packed {
        logic [KEPT_W-1:0] kept_length;
        logic              trimmed;
        logic              too_long;
    } t_result;

endpackage

[rtl/ptt_scan.sv]
`timescale 1ns / 1ps

module ptt_scan #(
    parameter int MAX_READ_LEN = ptt_pkg::MAX_READ_LEN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic [ptt_pkg::BASE_W-1:0]     i_base,
    input  logic                           i_head,
    input  logic [ptt_pkg::BASE_W-1:0]     i_target_base,
    input  logic [ptt_pkg::MIN_RUN_W-1:0]  i_min_run,
    output logic                           o_res_valid,
    output ptt_pkg::t_result               o_res
);
    import ptt_pkg::*;

    localparam int SEEN_W = $clog2(MAX_READ_LEN + 2);
    localparam int DIST_W = $clog2(MAX_READ_LEN);
    localparam int CMP_W  = (SEEN_W > MIN_RUN_W) ? SEEN_W : MIN_RUN_W;
    localparam logic [SEEN_W-1:0] SEEN_MAX  = SEEN_W'(MAX_READ_LEN);
    localparam logic [KEPT_W-1:0] KEPT_LONG = KEPT_W'(MAX_READ_LEN);

    logic [SEEN_W-1:0]     r_seen, n_seen;
    logic [MISMATCH_W-1:0] r_mis, n_mis;
    logic [DIST_W-1:0]     r_dist, n_dist;
    logic                  r_stopped, n_stopped;

    logic                  w_over;
    logic [MISMATCH_W-1:0] w_mis;
    logic [DIST_W-1:0]     w_dist;
    logic                  w_stop;
    logic [CMP_W-1:0]      w_seen_ext;
    logic [CMP_W-1:0]      w_min_ext;

    assign w_min_ext = CMP_W'(i_min_run);

    always_comb begin
        // The count saturates one past the maximum so an overlong read stays flagged.
        n_seen     = (r_seen <= SEEN_MAX) ? r_seen + 1'b1 : r_seen;
        w_seen_ext = CMP_W'(n_seen);
        w_over     = n_seen > SEEN_MAX;
        w_stop     = r_stopped | w_over;
        w_mis      = r_mis;
        w_dist     = r_dist;
        if (!w_stop) begin
            if (i_base == i_target_base) begin
                w_dist = DIST_W'(n_seen - 1'b1);
            end else begin
                w_mis = r_mis + 1'b1;
            end
            if ((w_mis > MISMATCH_CAP) ||
                ((CMP_W'(w_mis) > CMP_W'(n_seen >> MISMATCH_SPAN_LOG2)) &&
                 (w_seen_ext >= w_min_ext))) begin
                w_stop = 1'b1;
            end
        end

        o_res_valid = i_step & i_head;
        if (w_over) begin
            o_res.kept_length = KEPT_LONG;
            o_res.trimmed     = 1'b0;
        end else if (CMP_W'(w_dist) + 1'b1 >= w_min_ext) begin
            o_res.kept_length = KEPT_W'(n_seen - 1'b1 - SEEN_W'(w_dist));
            o_res.trimmed     = 1'b1;
        end else begin
            o_res.kept_length = KEPT_W'(n_seen);
            o_res.trimmed     = 1'b0;
        end
        o_res.too_long = w_over;

        // The head base closes the read and clears the scan for the next one.
        if (i_head) begin
            n_seen    = '0;
            n_mis     = '0;
            n_dist    = '0;
            n_stopped = 1'b0;
        end else begin
            n_mis     = w_mis;
            n_dist    = w_dist;
            n_stopped = w_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen    <= '0;
            r_mis     <= '0;
            r_dist    <= '0;
            r_stopped <= 1'b0;
        end else if (i_step) begin
            r_seen    <= n_seen;
            r_mis     <= n_mis;
            r_dist    <= n_dist;
            r_stopped <= n_stopped;
        end
    end

endmodule

[rtl/poly_base_tail_trimmer_core.sv]
`timescale 1ns / 1ps

// Channel   Dir  Beat contents
// s_axis    in   tdata[7:0] base, tlast head_base (head-most base of the read)
// m_axis    out  tdata[10:0] kept_length, tuser[0] trimmed, tuser[1] too_long
// apb       in   reg 0 at 0x0 target_base, reg 1 at 0x4 min_run
//
// One base is accepted per cycle while s_axis tready is high. A base is held in the
// input register and scanned into the state when the scan stage advances; on the head
// base the result register loads at that same edge, so tvalid rises once the head
// base is scanned. Reset is synchronous and clears the read state and the registers
// to defaults. A stall on m_axis fills the result register, then the input
// register, and only then drops s_axis tready.

module poly_base_tail_trimmer_core #(
    parameter int MAX_READ_LEN = ptt_pkg::MAX_READ_LEN_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Input stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [7:0]                      i_s_axis_tdata,   // [7:0] base
    input  logic                            i_s_axis_tlast,
    // Result stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [15:0]                     o_m_axis_tdata,   // [10:0] kept_length, rest 0
    output logic [1:0]                      o_m_axis_tuser,   // [0] trimmed, [1] too_long
    // Configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ptt_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ptt_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ptt_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import ptt_pkg::*;

    logic [BASE_W-1:0]    r_target_base;
    logic [MIN_RUN_W-1:0] r_min_run;

    logic                 r_in_valid;
    logic [BASE_W-1:0]    r_in_base;
    logic                 r_in_head;

    logic                 r_out_valid;
    t_result              r_out;

    logic                 w_advance;
    logic                 w_res_valid;
    t_result              w_res;

    // ---------------- Configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_base <= TARGET_BASE_RST;
            r_min_run     <= MIN_RUN_RST;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[2])
                REG_TARGET_BASE: r_target_base <= pwdata[BASE_W-1:0];
                REG_MIN_RUN:     r_min_run     <= pwdata[MIN_RUN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_TARGET_BASE: prdata = APB_DATA_W'(r_target_base);
            REG_MIN_RUN:     prdata = APB_DATA_W'(r_min_run);
            default:         prdata = '0;
        endcase
    end

    // ---------------- Input register ----------------
    // The scan stage moves whenever the result register can take a new value.
    assign w_advance       = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready && i_s_axis_tvalid) begin
            r_in_base <= i_s_axis_tdata;
            r_in_head <= i_s_axis_tlast;
        end
    end

    // ---------------- Scan ----------------
    ptt_scan #(
        .MAX_READ_LEN (MAX_READ_LEN)
    ) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (r_in_valid && w_advance),
        .i_base        (r_in_base),
        .i_head        (r_in_head),
        .i_target_base (r_target_base),
        .i_min_run     (r_min_run),
        .o_res_valid   (w_res_valid),
        .o_res         (w_res)
    );

    // ---------------- Result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= w_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = 16'(r_out.kept_length);
    assign o_m_axis_tuser  = {r_out.too_long, r_out.trimmed};

endmodule
